// ----- rtl/mlrc_pkg.sv -----
// mlrc_pkg: widths, limits, reset values and register indexes of the
// motion light ramp controller; no dependencies
`default_nettype none

package mlrc_pkg;

    // stream and configuration port widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_FIELD_W = 18;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // field widths
    localparam int RAMP_W    = 7;
    localparam int HOLD_W    = 4;
    localparam int DIV_W     = 16;
    localparam int LEVEL_W   = 5;
    localparam int ELAPSED_W = 13;
    localparam int DUTY_W    = 8;
    localparam int PROD_W    = RAMP_W + LEVEL_W;

    // limits
    localparam int MAX_LEVEL        = 20;
    localparam int MAX_RAMP         = 100;
    localparam int LEVEL_FIELD_MAX  = 31;
    localparam int TICKS_PER_MINUTE = 600;
    localparam logic [LEVEL_W-1:0] LEVEL_CAP = (MAX_LEVEL > LEVEL_FIELD_MAX) ?
        LEVEL_W'(LEVEL_FIELD_MAX) : LEVEL_W'(MAX_LEVEL);
    localparam logic [HOLD_W-1:0] HOLD_LIMIT = HOLD_W'(10);

    // serial divider: two quotient bits per cycle
    localparam int DIV_BITS_PER_CYCLE = 2;
    localparam int DIV_CYCLES         = PROD_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = 3;

    // register reset values
    localparam logic [RAMP_W-1:0]  RST_RAMP_UP  = RAMP_W'(30);
    localparam logic [RAMP_W-1:0]  RST_FADE     = RAMP_W'(30);
    localparam logic [HOLD_W-1:0]  RST_HOLD     = HOLD_W'(3);
    localparam logic [DIV_W-1:0]   RST_TICK_DIV = DIV_W'(200);
    localparam logic [LEVEL_W-1:0] RST_POWER    = LEVEL_W'(4);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_UP_TICKS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_TICKS     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MINUTES   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_DIVIDER   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_AT_RESET = CFG_IDX_W'(4);

    function automatic logic [RAMP_W-1:0] sat_ramp(input logic [RAMP_W-1:0] v);
        sat_ramp = (int'(v) > MAX_RAMP) ? RAMP_W'(MAX_RAMP) : v;
    endfunction

    function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] v);
        sat_level = (v > LEVEL_CAP) ? LEVEL_CAP : v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/motion_light_ramp_controller.sv -----
// motion_light_ramp_controller: two-channel motion light sequencer with a
// shared serial divider for the ramp and fade duty values; uses mlrc_pkg
// - slave stream: one request per sensor/button poll; tdata carries
//   sensor_a, sensor_b, button_plus, button_minus (bits 0..3, active-low buttons)
// - master stream: one result per poll with duty_a, duty_b, heartbeat and
//   logic_tick; duties are the values held since the last logic tick
// - config channel: i_cfg_index selects ramp_up_ticks, fade_ticks,
//   hold_minutes, tick_divider or power_at_reset; always ready; the user must
//   see that it is written only while no poll is in flight, which the block
//   does not enforce; a power_at_reset write also loads the power level
// - a poll without a logic tick goes straight to the done state; a logic
//   tick poll runs per channel a setup state, plus the divider state and a
//   store state when the duty is a ramp or fade fraction, then a power
//   update state, before the done state posts the result
// - a new poll is accepted only once the last one has posted its result;
//   the 2-bit-per-cycle divider shared by both channels slows tick polls
// - reset (synchronous, active low) loads the register defaults, clears
//   all channel state and drops the result valid
// - a stalled receiver holds the result in the output register; the next
//   poll is still accepted and runs, and waits to post its result
`default_nettype none

module motion_light_ramp_controller (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [0] sensor_a, [1] sensor_b, [2] button_plus, [3] button_minus, [7:4] zero
    input  wire logic [mlrc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [7:0] duty_a, [15:8] duty_b, [16] heartbeat, [17] logic_tick, [23:18] zero
    output logic [mlrc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [mlrc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mlrc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mlrc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SETUP = 6'b000010,
        S_DIV   = 6'b000100,
        S_STORE = 6'b001000,
        S_POWER = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;

    // configuration registers
    logic [RAMP_W-1:0]  r_ramp_cfg;
    logic [RAMP_W-1:0]  r_fade_cfg;
    logic [HOLD_W-1:0]  r_hold_cfg;
    logic [DIV_W-1:0]   r_tick_div;

    // light state
    logic [DIV_W-1:0]     r_poll_count;
    logic [1:0]           r_last_sensor;
    logic [1:0]           r_last_button;
    logic [1:0]           r_pending;
    logic [1:0]           r_running;
    logic [ELAPSED_W-1:0] r_elapsed   [2];
    logic [RAMP_W-1:0]    r_fade_left [2];
    logic [DUTY_W-1:0]    r_duty      [2];
    logic [LEVEL_W-1:0]   r_power;
    logic                 r_beat;
    logic                 r_tick;
    logic                 r_ch;

    // shared divider
    logic [PROD_W-1:0]    r_quo;
    logic [RAMP_W-1:0]    r_rem;
    logic [RAMP_W-1:0]    r_dvsr;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic in_acc;
    logic out_free;
    logic sa, sb, bp, bm;
    logic tick_now;

    logic [RAMP_W-1:0]    ramp_sat;
    logic [RAMP_W-1:0]    fade_sat;
    logic [HOLD_W-1:0]    hold_sat;
    logic [ELAPSED_W-1:0] hold_ticks;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [RAMP_W-1:0]    fade_dec;
    logic [RAMP_W-1:0]    mult_a;
    logic [PROD_W-1:0]    product;

    logic                 n_running_c;
    logic [ELAPSED_W-1:0] n_elapsed_c;
    logic [RAMP_W-1:0]    n_fade_left_c;
    logic [DUTY_W-1:0]    n_duty_c;
    logic                 n_duty_we;
    logic                 n_need_div;
    logic [RAMP_W-1:0]    n_divisor;

    logic [PROD_W-1:0]    n_quo;
    logic [RAMP_W-1:0]    n_rem;
    logic [LEVEL_W-1:0]   n_power;

    assign in_acc   = s_axis_tvalid & s_axis_tready;
    assign out_free = ~r_out_valid | m_axis_tready;
    assign sa = s_axis_tdata[0];
    assign sb = s_axis_tdata[1];
    assign bp = s_axis_tdata[2];
    assign bm = s_axis_tdata[3];
    assign tick_now = (r_poll_count >= r_tick_div);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign o_cfg_ready   = 1'b1;

    // saturated configuration
    assign ramp_sat   = sat_ramp(r_ramp_cfg);
    assign fade_sat   = sat_ramp(r_fade_cfg);
    assign hold_sat   = (r_hold_cfg > HOLD_LIMIT) ? HOLD_LIMIT : r_hold_cfg;
    assign hold_ticks = ELAPSED_W'(hold_sat) * ELAPSED_W'(TICKS_PER_MINUTE);

    // channel step of the selected channel; the fraction goes to the divider
    assign elapsed_inc = r_elapsed[r_ch] + 1'b1;
    assign fade_dec    = r_fade_left[r_ch] - 1'b1;
    // in the ramp phase elapsed stays below the ramp length, so 7 bits suffice
    assign mult_a      = r_running[r_ch] ? elapsed_inc[RAMP_W-1:0] : r_fade_left[r_ch];
    assign product     = PROD_W'(mult_a) * PROD_W'(r_power);

    always_comb begin
        n_running_c   = r_running[r_ch];
        n_elapsed_c   = r_elapsed[r_ch];
        n_fade_left_c = r_fade_left[r_ch];
        n_duty_c      = '0;
        n_duty_we     = 1'b0;
        n_need_div    = 1'b0;
        n_divisor     = ramp_sat;
        if (r_running[r_ch]) begin
            n_elapsed_c = elapsed_inc;
            if (elapsed_inc < ELAPSED_W'(ramp_sat)) begin
                n_need_div = 1'b1;
            end else if (elapsed_inc > hold_ticks) begin
                // hold time over: start the fade, duty keeps its value
                n_running_c   = 1'b0;
                n_elapsed_c   = '0;
                n_fade_left_c = fade_sat;
            end else begin
                n_duty_we = 1'b1;
                n_duty_c  = DUTY_W'(r_power);
            end
        end else if (r_fade_left[r_ch] != '0) begin
            n_fade_left_c = fade_dec;
            if (fade_dec == '0) begin
                n_duty_we = 1'b1;
            end else begin
                n_need_div = 1'b1;
                n_divisor  = (fade_sat == '0) ? RAMP_W'(1) : fade_sat;
            end
        end else begin
            n_duty_we = 1'b1;
        end
    end

    // restoring divider, two quotient bits per cycle
    always_comb begin
        logic [RAMP_W:0] trial;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
            trial = {n_rem, n_quo[PROD_W-1]};
            if (trial >= {1'b0, r_dvsr}) begin
                trial = trial - {1'b0, r_dvsr};
                n_quo = {n_quo[PROD_W-2:0], 1'b1};
            end else begin
                n_quo = {n_quo[PROD_W-2:0], 1'b0};
            end
            n_rem = trial[RAMP_W-1:0];
        end
    end

    // pending plus, then pending minus, with saturation
    always_comb begin
        n_power = r_power;
        if (r_pending[0] && (n_power < LEVEL_CAP)) begin
            n_power = n_power + 1'b1;
        end
        if (r_pending[1] && (n_power != '0)) begin
            n_power = n_power - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ramp_cfg    <= RST_RAMP_UP;
            r_fade_cfg    <= RST_FADE;
            r_hold_cfg    <= RST_HOLD;
            r_tick_div    <= RST_TICK_DIV;
            r_poll_count  <= '0;
            r_last_sensor <= '0;
            r_last_button <= '1;
            r_pending     <= '0;
            r_running     <= '0;
            r_elapsed[0]  <= '0;
            r_elapsed[1]  <= '0;
            r_fade_left[0] <= '0;
            r_fade_left[1] <= '0;
            r_duty[0]     <= '0;
            r_duty[1]     <= '0;
            r_power       <= sat_level(RST_POWER);
            r_beat        <= 1'b0;
            r_tick        <= 1'b0;
            r_ch          <= 1'b0;
            r_div_cnt     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_RAMP_UP_TICKS:  r_ramp_cfg <= i_cfg_data[RAMP_W-1:0];
                    CFG_FADE_TICKS:     r_fade_cfg <= i_cfg_data[RAMP_W-1:0];
                    CFG_HOLD_MINUTES:   r_hold_cfg <= i_cfg_data[HOLD_W-1:0];
                    CFG_TICK_DIVIDER:   r_tick_div <= i_cfg_data[DIV_W-1:0];
                    CFG_POWER_AT_RESET: begin
                        r_power <= sat_level(i_cfg_data[LEVEL_W-1:0]);
                    end
                    default: ;
                endcase
            end

            // the done state posts the next result itself
            if (m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        // sensor edges act on every poll
                        if (sa && !r_last_sensor[0]) begin
                            r_running[0]   <= 1'b1;
                            r_fade_left[0] <= '0;
                            if (r_elapsed[0] > ELAPSED_W'(ramp_sat)) begin
                                r_elapsed[0] <= ELAPSED_W'(ramp_sat);
                            end
                        end
                        if (sb && !r_last_sensor[1] && (r_elapsed[1] == '0)) begin
                            r_running[1] <= 1'b1;
                        end
                        r_last_sensor <= {sb, sa};
                        r_pending[0]  <= r_pending[0] | (~bp & r_last_button[0]);
                        r_pending[1]  <= r_pending[1] | (~bm & r_last_button[1]);
                        r_last_button <= {bm, bp};
                        r_ch <= 1'b0;
                        if (tick_now) begin
                            r_poll_count <= '0;
                            r_beat       <= ~r_beat;
                            r_tick       <= 1'b1;
                            r_state      <= S_SETUP;
                        end else begin
                            r_poll_count <= r_poll_count + 1'b1;
                            r_tick       <= 1'b0;
                            r_state      <= S_DONE;
                        end
                    end
                end
                S_SETUP: begin
                    r_running[r_ch]   <= n_running_c;
                    r_elapsed[r_ch]   <= n_elapsed_c;
                    r_fade_left[r_ch] <= n_fade_left_c;
                    if (n_duty_we) begin
                        r_duty[r_ch] <= n_duty_c;
                    end
                    if (n_need_div) begin
                        r_div_cnt <= '0;
                        r_state   <= S_DIV;
                    end else if (!r_ch) begin
                        r_ch <= 1'b1;
                    end else begin
                        r_state <= S_POWER;
                    end
                end
                S_DIV: begin
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    // duty keeps only the low bits of the quotient
                    r_duty[r_ch] <= r_quo[DUTY_W-1:0];
                    if (!r_ch) begin
                        r_ch    <= 1'b1;
                        r_state <= S_SETUP;
                    end else begin
                        r_state <= S_POWER;
                    end
                end
                S_POWER: begin
                    // duties above used the old level
                    r_power   <= n_power;
                    r_pending <= '0;
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_SETUP) begin
            r_quo  <= product;
            r_rem  <= '0;
            r_dvsr <= n_divisor;
        end else if (r_state == S_DIV) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_data <= {{OUT_PAD_W{1'b0}}, r_tick, r_beat, r_duty[1], r_duty[0]};
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mlrc_checker.sv -----
// mlrc_checker: port-level checks of the motion light ramp controller,
// bound to the top level; uses mlrc_pkg
`default_nettype none

module mlrc_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [mlrc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import mlrc_pkg::*;

    // one request at a time: busy right after an accepted poll
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("poll accepted while previous one in flight");

    // a stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // padding bits stay clear
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:OUT_FIELD_W] == '0))
        else $error("result padding not zero");

    // reset drops the result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind motion_light_ramp_controller mlrc_checker u_mlrc_checker (.*);

`default_nettype wire

// ----- sim/motion_light_ramp_controller_tb.sv -----
`timescale 1ns / 100ps
// motion_light_ramp_controller_tb: self-checking bench for the two-channel motion light
// controller; predicts every poll result and scoreboards it in order
// depends on mlrc_pkg and rtl/motion_light_ramp_controller.sv

module motion_light_ramp_controller_tb;
    import mlrc_pkg::*;

    localparam int RUN_LIMIT_NS  = 5_000_000;  // far beyond the slowest legal run
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 30;         // room for the longest logic tick poll
    localparam int LONG_HOLD_OFF = 250;
    localparam int MAX_REPORTS   = 10;
    localparam int KEEP_POWER    = -1;         // leave power_at_reset alone
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(7);

    // result word, duty_a in the lowest bits
    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic                 logic_tick;
        logic                 heartbeat;
        logic [DUTY_W-1:0]    duty_b;
        logic [DUTY_W-1:0]    duty_a;
    } lamp_out_t;

    // poll request, sensor_a in bit 0
    typedef struct packed {
        logic button_minus;
        logic button_plus;
        logic sensor_b;
        logic sensor_a;
    } poll_t;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    motion_light_ramp_controller dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor copy of the registers and channel state
    // ------------------------------------------------------------------
    logic [RAMP_W-1:0]    reg_ramp_up;
    logic [RAMP_W-1:0]    reg_fade;
    logic [HOLD_W-1:0]    reg_hold;
    logic [DIV_W-1:0]     reg_tick_div;
    logic [LEVEL_W-1:0]   reg_power_init;

    logic [DIV_W-1:0]     poll_cnt;
    logic                 prev_sensor  [2];
    logic                 prev_button  [2];   // [0] plus, [1] minus
    logic                 press_req    [2];
    logic                 ch_running   [2];
    logic [ELAPSED_W-1:0] ch_elapsed   [2];
    logic [RAMP_W-1:0]    ch_fade_left [2];
    logic [DUTY_W-1:0]    ch_duty      [2];
    logic [LEVEL_W-1:0]   power_lvl;
    logic                 beat_lvl;

    lamp_out_t expected_q [$];     // one entry per accepted poll request
    int        fail_count    = 0;
    bit        no_idle       = 1'b0; // both sides run without gaps
    bit        hold_off_req  = 1'b0; // receiver starts one long stall
    poll_t     line_lvl      = '{button_minus: 1'b1, button_plus: 1'b1,
                                 sensor_b: 1'b0, sensor_a: 1'b0};

    function automatic logic [RAMP_W-1:0] clip_ramp(input logic [RAMP_W-1:0] v);
        return (int'(v) > MAX_RAMP) ? RAMP_W'(MAX_RAMP) : v;
    endfunction

    function automatic logic [LEVEL_W-1:0] cap_level(input logic [LEVEL_W-1:0] v);
        return (v > LEVEL_CAP) ? LEVEL_CAP : v;
    endfunction

    // one logic tick of a channel: ramp, hold, then fade
    function automatic void advance_channel(input int c);
        int ramp, fade, hold, div, e;
        ramp = int'(clip_ramp(reg_ramp_up));
        fade = int'(clip_ramp(reg_fade));
        hold = (reg_hold > HOLD_LIMIT) ? int'(HOLD_LIMIT) : int'(reg_hold);
        if (ch_running[c]) begin
            ch_elapsed[c] = ch_elapsed[c] + 1'b1;
            e = int'(ch_elapsed[c]);
            if (e < ramp) begin
                ch_duty[c] = DUTY_W'(e * int'(power_lvl) / ramp);
            end else if (e > TICKS_PER_MINUTE * hold) begin
                // on time over: duty stays, fade starts next tick
                ch_running[c]   = 1'b0;
                ch_elapsed[c]   = '0;
                ch_fade_left[c] = RAMP_W'(fade);
            end else begin
                ch_duty[c] = DUTY_W'(power_lvl);
            end
        end else if (ch_fade_left[c] != 0) begin
            div = (fade == 0) ? 1 : fade;
            ch_duty[c] = DUTY_W'(int'(ch_fade_left[c]) * int'(power_lvl) / div);
            ch_fade_left[c] = ch_fade_left[c] - 1'b1;
            if (ch_fade_left[c] == 0) ch_duty[c] = '0;
        end else begin
            ch_duty[c] = '0;
        end
    endfunction

    // full poll: edge detection every poll, logic step on the divider wrap
    function automatic lamp_out_t predict_poll(input poll_t p);
        lamp_out_t r;
        logic      ticked;
        ticked = 1'b0;
        if (p.sensor_a && !prev_sensor[0]) begin
            // channel a restarts at once, elapsed pulled back to the ramp end
            ch_running[0]   = 1'b1;
            ch_fade_left[0] = '0;
            if (int'(ch_elapsed[0]) > int'(clip_ramp(reg_ramp_up)))
                ch_elapsed[0] = ELAPSED_W'(clip_ramp(reg_ramp_up));
        end
        prev_sensor[0] = p.sensor_a;
        // channel b only starts from idle
        if (p.sensor_b && !prev_sensor[1] && ch_elapsed[1] == 0) ch_running[1] = 1'b1;
        prev_sensor[1] = p.sensor_b;
        if (!p.button_plus && prev_button[0]) press_req[0] = 1'b1;
        prev_button[0] = p.button_plus;
        if (!p.button_minus && prev_button[1]) press_req[1] = 1'b1;
        prev_button[1] = p.button_minus;

        if (poll_cnt < reg_tick_div) begin
            poll_cnt = poll_cnt + 1'b1;
        end else begin
            poll_cnt = '0;
            ticked   = 1'b1;
            beat_lvl = ~beat_lvl;
            advance_channel(0);
            advance_channel(1);
            // power changes after the duties, so they used the old level
            if (press_req[0]) begin
                if (power_lvl < LEVEL_CAP) power_lvl = power_lvl + 1'b1;
                press_req[0] = 1'b0;
            end
            if (press_req[1]) begin
                if (power_lvl > 0) power_lvl = power_lvl - 1'b1;
                press_req[1] = 1'b0;
            end
        end
        r.pad        = '0;
        r.logic_tick = ticked;
        r.heartbeat  = beat_lvl;
        r.duty_b     = ch_duty[1];
        r.duty_a     = ch_duty[0];
        return r;
    endfunction

    function automatic void predict_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_RAMP_UP_TICKS: reg_ramp_up  = d[RAMP_W-1:0];
            CFG_FADE_TICKS:    reg_fade     = d[RAMP_W-1:0];
            CFG_HOLD_MINUTES:  reg_hold     = d[HOLD_W-1:0];
            CFG_TICK_DIVIDER:  reg_tick_div = d[DIV_W-1:0];
            CFG_POWER_AT_RESET: begin
                // a power write also loads the live level
                reg_power_init = d[LEVEL_W-1:0];
                power_lvl      = cap_level(reg_power_init);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // mostly short gaps, a few long ones
    function automatic int rand_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // register value with random junk above the field
    function automatic logic [CFG_DATA_W-1:0] with_noise(input int value, input int width);
        logic [CFG_DATA_W-1:0] mask, junk;
        mask = (CFG_DATA_W'(1) << width) - 1'b1;
        junk = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom) : '0;
        return (junk & ~mask) | (CFG_DATA_W'(value) & mask);
    endfunction

    function automatic poll_t make_poll(input logic sa, input logic sb,
                                        input logic bp, input logic bm);
        poll_t p;
        p.sensor_a     = sa;
        p.sensor_b     = sb;
        p.button_plus  = bp;
        p.button_minus = bm;
        return p;
    endfunction

    // one poll request; valid stays high when the next follows at once
    task automatic send_poll(input poll_t p);
        int gap;
        gap = rand_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-4){1'b0}}, p};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        expected_q.push_back(predict_poll(p));
    endtask

    // register write; the caller lowers valid after its last write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        predict_write(idx, d);
    endtask

    // only called while idle
    task automatic apply_setup(input int ramp, input int fade, input int hold,
                               input int div, input int power);
        cfg_write(CFG_RAMP_UP_TICKS, with_noise(ramp, RAMP_W));
        cfg_write(CFG_FADE_TICKS, with_noise(fade, RAMP_W));
        cfg_write(CFG_HOLD_MINUTES, with_noise(hold, HOLD_W));
        cfg_write(CFG_TICK_DIVIDER, with_noise(div, DIV_W));
        if (power != KEEP_POWER) cfg_write(CFG_POWER_AT_RESET, with_noise(power, LEVEL_W));
        // a write to an index with no register must change nothing
        if ($urandom_range(0, 3) == 0) cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // wait for every expected result, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly held sensor levels and short button presses, some pure noise
    task automatic run_random(input int count, input int sensor_pct,
                              input int plus_pct, input int minus_pct);
        poll_t p;
        repeat (count) begin
            if ($urandom_range(0, 99) < 12) begin
                p = poll_t'(4'($urandom));
            end else begin
                if ($urandom_range(0, 99) < sensor_pct) line_lvl.sensor_a = ~line_lvl.sensor_a;
                if ($urandom_range(0, 99) < sensor_pct) line_lvl.sensor_b = ~line_lvl.sensor_b;
                // released stays up unless pressed, pressed lets go half the time
                line_lvl.button_plus = line_lvl.button_plus ?
                    ($urandom_range(0, 99) >= plus_pct) : ($urandom_range(0, 1) == 1);
                line_lvl.button_minus = line_lvl.button_minus ?
                    ($urandom_range(0, 99) >= minus_pct) : ($urandom_range(0, 1) == 1);
                p = line_lvl;
            end
            send_poll(p);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // reset defaults: divider of 200 means no logic tick for these polls
    task automatic test_reset_values();
        send_poll(make_poll(1, 1, 0, 0));
        send_poll(make_poll(0, 0, 1, 1));
        send_poll(make_poll(1, 0, 1, 0));
        send_poll(make_poll(0, 1, 0, 1));
        send_poll(make_poll(1, 1, 1, 1));
        send_poll(make_poll(0, 0, 1, 1));
        drain();
    endtask

    task automatic test_special_cases();
        // ramp and fade above the limit, hold above ten, power above the cap
        apply_setup(127, 127, 15, 0, 31);
        send_poll(make_poll(1, 1, 0, 1));
        send_poll(make_poll(1, 1, 1, 0));
        send_poll(make_poll(0, 0, 1, 1));
        drain();
        // short ramp and zero hold end both channels with a full fade count
        apply_setup(1, 127, 0, 0, KEEP_POWER);
        send_poll(make_poll(0, 0, 1, 1));
        drain();
        // fade divisor of one: fade fraction overflows the duty width
        apply_setup(1, 1, 0, 0, KEEP_POWER);
        send_poll(make_poll(0, 0, 1, 1));
        drain();
        // zero fade divisor while fading
        apply_setup(1, 0, 0, 0, KEEP_POWER);
        send_poll(make_poll(0, 0, 1, 1));
        send_poll(make_poll(0, 0, 1, 1));
        drain();
        // zero ramp goes straight to hold; power write loads the level
        apply_setup(0, 2, 0, 0, 7);
        send_poll(make_poll(1, 1, 1, 1));
        send_poll(make_poll(0, 0, 1, 1));
        send_poll(make_poll(0, 0, 1, 1));
        drain();
        // largest divider: no tick, then the count is past a divider of zero
        apply_setup(3, 3, 0, 16'hFFFF, KEEP_POWER);
        send_poll(make_poll(1, 0, 0, 1));
        send_poll(make_poll(0, 1, 1, 0));
        send_poll(make_poll(0, 0, 1, 1));
        drain();
        apply_setup(3, 3, 0, 0, 0);
        send_poll(make_poll(1, 1, 1, 1));
        send_poll(make_poll(0, 0, 1, 1));
        drain();
    endtask

    // a tick on every poll, short ramps and fades, power pushed to both ends
    task automatic test_fast_ticks();
        int power;
        for (int round = 0; round < 4; round++) begin
            power = (round == 0) ? 31 : (round == 3) ? 0 : $urandom_range(0, 20);
            apply_setup($urandom_range(1, 10), $urandom_range(1, 10), 0, 0, power);
            run_random(60, 15, (round == 1) ? 25 : 4, (round == 2) ? 25 : 4);
            drain();
        end
    endtask

    // receiver stalls long while polls keep coming, then no gaps at all
    task automatic test_backpressure();
        apply_setup(4, 4, 0, 0, KEEP_POWER);
        no_idle      = 1'b1;
        hold_off_req = 1'b1;
        run_random(40, 20, 5, 5);
        drain();
        no_idle = 1'b0;
    endtask

    // ticks every few polls, ramps and fades of any length
    task automatic test_slow_ticks();
        int ramp, fade;
        repeat (3) begin
            ramp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12);
            fade = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12);
            apply_setup(ramp, fade, 0, $urandom_range(1, 5), KEEP_POWER);
            run_random(60, 10, 6, 6);
            drain();
        end
    endtask

    // one minute of hold: full level reached, retrigger during hold
    task automatic test_full_hold();
        apply_setup($urandom_range(5, 40), $urandom_range(5, 40), 1, 0, 20);
        run_random(650, 1, 3, 1);
        drain();
    endtask

    // ------------------------------------------------------------------
    // receiver: random tready, plus one long counted hold-off on request
    // ------------------------------------------------------------------
    initial begin : receiver
        int stall_left;
        int gap;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_off_req) begin
                hold_off_req  = 1'b0;
                stall_left    = LONG_HOLD_OFF - 1;
                m_axis_tready <= 1'b0;
            end else begin
                gap           = rand_gap();
                stall_left    = (gap > 0) ? gap - 1 : 0;
                m_axis_tready <= (gap == 0);
            end
        end
    end

    // ------------------------------------------------------------------
    // result checker: in-order compare against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        lamp_out_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: result %h with no poll outstanding", $realtime, got);
            end else begin
                want = expected_q.pop_front();
                if (got.duty_a !== want.duty_a || got.duty_b !== want.duty_b ||
                    got.heartbeat !== want.heartbeat || got.logic_tick !== want.logic_tick ||
                    got.pad !== want.pad) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: mismatch exp a=%0d b=%0d hb=%0b tick=%0b pad=%h, got a=%0d b=%0d hb=%0b tick=%0b pad=%h",
                                 $realtime, want.duty_a, want.duty_b, want.heartbeat,
                                 want.logic_tick, want.pad, got.duty_a, got.duty_b,
                                 got.heartbeat, got.logic_tick, got.pad);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        reg_ramp_up    = RST_RAMP_UP;
        reg_fade       = RST_FADE;
        reg_hold       = RST_HOLD;
        reg_tick_div   = RST_TICK_DIV;
        reg_power_init = RST_POWER;
        poll_cnt       = '0;
        for (int c = 0; c < 2; c++) begin
            prev_sensor[c]  = 1'b0;
            prev_button[c]  = 1'b1;
            press_req[c]    = 1'b0;
            ch_running[c]   = 1'b0;
            ch_elapsed[c]   = '0;
            ch_fade_left[c] = '0;
            ch_duty[c]      = '0;
        end
        power_lvl = cap_level(RST_POWER);
        beat_lvl  = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_special_cases();
        test_fast_ticks();
        test_backpressure();
        test_slow_ticks();
        test_full_hold();

        if (fail_count == 0) begin
            $display("PASS motion_light_ramp_controller");
        end else begin
            $display("FAIL motion_light_ramp_controller");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAIL motion_light_ramp_controller");
        $finish;
    end

endmodule

// ----- motion_light_ramp_controller.f -----
rtl/mlrc_pkg.sv
rtl/motion_light_ramp_controller.sv
rtl/mlrc_checker.sv
sim/motion_light_ramp_controller_tb.sv
